// ----- rtl/hexq_pkg.sv -----
// Shared widths, constants and the segment table for the hex element quality block.
// No dependencies.
`default_nettype none
package hexq_pkg;
	localparam int COORD_BITS    = 24;
	localparam int FRACTION_BITS = 16;
	localparam int RATIO_FRAC    = 16;
	localparam int NUM_EDGES     = 12;
	localparam int NUM_DIAGS     = 4;
	localparam int NUM_SEGS      = NUM_EDGES + NUM_DIAGS;
	localparam int SEG_BITS      = $clog2(NUM_SEGS);
	localparam int SQ_BITS       = 2 * COORD_BITS + 2;   // sum of three squares
	localparam int LEN_BITS      = SQ_BITS / 2;          // square root width
	localparam int RATIO_BITS    = 32;
	localparam int DIAM_BITS     = 25;
	localparam int DVD_BITS      = LEN_BITS + RATIO_FRAC;
	localparam int VERT_BITS     = 3 * COORD_BITS;

	typedef logic [COORD_BITS-1:0] coord_t;
	typedef logic [LEN_BITS-1:0]   len_t;
	typedef logic [2:0]            corner_t;
	typedef logic [SEG_BITS-1:0]   seg_t;

	typedef struct packed {
		coord_t z;
		coord_t y;
		coord_t x;
	} vertex_t;

	// Edges 01,12,23,03,45,56,67,47,04,15,26,37 then diagonals 06,17,24,35.
	function automatic corner_t seg_corner_a(input seg_t idx);
		corner_t c;
		unique case (idx)
			4'd0, 4'd3, 4'd8, 4'd12:  c = 3'd0;
			4'd1, 4'd9, 4'd13:        c = 3'd1;
			4'd2, 4'd10, 4'd14:       c = 3'd2;
			4'd11, 4'd15:             c = 3'd3;
			4'd4, 4'd7:               c = 3'd4;
			4'd5:                     c = 3'd5;
			default:                  c = 3'd6;
		endcase
		return c;
	endfunction

	function automatic corner_t seg_corner_b(input seg_t idx);
		corner_t c;
		unique case (idx)
			4'd0:                     c = 3'd1;
			4'd1:                     c = 3'd2;
			4'd2, 4'd3:               c = 3'd3;
			4'd8, 4'd14:              c = 3'd4;
			4'd4, 4'd9, 4'd15:        c = 3'd5;
			4'd5, 4'd10, 4'd12:       c = 3'd6;
			default:                  c = 3'd7;
		endcase
		return c;
	endfunction
endpackage
`default_nettype wire

// ----- rtl/hex_element_quality_unit.sv -----
// Top level: corner store, segment sequencer, ratio divider and output register.
// Depends on hexq_pkg and hexq_seg_unit.
//
//  channel   | direction | request carries
//  s_*       | in        | tuser: corner_index; tdata: coord_x, coord_y, coord_z
//  m_*       | out       | tdata: edge_ratio, diameter, exceeds_critical, degenerate
//  cfg_*     | in        | cfg_data: critical_edge_ratio
//
// Corners 0..6 are stored on acceptance. Corner 7 is also stored and starts a run
// over the 16 segments: per segment a store read, the start handoff, bit-serial
// squaring, square root and done; then restoring division (skipped when the
// shortest edge is zero) and the output state. Reset clears control state and
// sets the critical ratio to all ones; the corner store is not cleared.
// A finished result waits in the output register while new corners come in; a
// second run that finishes before it is taken stalls in its output cycle.
`default_nettype none
module hex_element_quality_unit import hexq_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [2:0]  s_tuser,   // [2:0] corner_index
	input  wire logic [71:0] s_tdata,   // [23:0] coord_x, [47:24] coord_y, [71:48] coord_z
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [63:0]      m_tdata,   // [31:0] edge_ratio, [56:32] diameter,
	                                    // [57] exceeds_critical, [58] degenerate, rest zero
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [31:0] cfg_data   // critical_edge_ratio
);
	typedef enum logic [2:0] {T_IDLE, T_READ, T_START, T_SEG, T_DIV, T_FIN} st_t;

	localparam int DCNT_BITS = $clog2(DVD_BITS);
	localparam int DREM_BITS = LEN_BITS + 1;

	st_t                   state_q;
	vertex_t               store_q [8];   // corner memory, two read ports
	vertex_t               rd_a_q, rd_b_q;
	seg_t                  seg_q;
	len_t                  lmax_q, lmin_q, diam_q;
	logic [RATIO_BITS-1:0] crit_q, ratio_q;
	logic                  degen_q;
	logic [DVD_BITS-1:0]   dvd_q, quo_q;
	logic [DREM_BITS-1:0]  drem_q;
	logic [DCNT_BITS-1:0]  dcnt_q;
	logic                  seg_start, seg_done;
	len_t                  seg_len;
	logic [DREM_BITS-1:0]  drem_sh;
	logic [RATIO_BITS-1:0] ratio_sat;
	logic                  out_valid_q;
	logic [63:0]           out_data_q;

	assign s_tready  = (state_q == T_IDLE);
	assign cfg_ready = 1'b1;
	assign m_tvalid  = out_valid_q;
	assign m_tdata   = out_data_q;
	assign seg_start = (state_q == T_START);
	assign drem_sh   = {drem_q[DREM_BITS-2:0], dvd_q[DVD_BITS-1]};
	assign ratio_sat = (quo_q[DVD_BITS-1:RATIO_BITS] != '0) ? '1 : quo_q[RATIO_BITS-1:0];

	hexq_seg_unit u_seg (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (seg_start),
		.va     (rd_a_q),
		.vb     (rd_b_q),
		.done   (seg_done),
		.length (seg_len)
	);

	// corner memory: write on accept, registered reads at the current segment
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready)
			store_q[s_tuser] <= s_tdata;
		rd_a_q <= store_q[seg_corner_a(seg_q)];
		rd_b_q <= store_q[seg_corner_b(seg_q)];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= T_IDLE;
			seg_q       <= '0;
			dcnt_q      <= '0;
			crit_q      <= '1;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready)
				crit_q <= cfg_data;
			if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				T_IDLE: begin
					if (s_tvalid && s_tuser == 3'd7) begin
						seg_q   <= '0;
						diam_q  <= '0;
						state_q <= T_READ;
					end
				end
				T_READ:  state_q <= T_START;
				T_START: state_q <= T_SEG;
				T_SEG: begin
					if (seg_done) begin
						if (seg_q == '0) begin
							lmax_q <= seg_len;
							lmin_q <= seg_len;
						end else if (seg_q < SEG_BITS'(NUM_EDGES)) begin
							if (seg_len > lmax_q) lmax_q <= seg_len;
							if (seg_len < lmin_q) lmin_q <= seg_len;
						end else if (seg_len > diam_q) begin
							diam_q <= seg_len;
						end
						if (seg_q == SEG_BITS'(NUM_SEGS - 1)) begin
							degen_q <= (lmin_q == '0);
							dvd_q   <= {lmax_q, {RATIO_FRAC{1'b0}}};
							drem_q  <= '0;
							quo_q   <= '0;
							dcnt_q  <= '0;
							state_q <= (lmin_q == '0) ? T_FIN : T_DIV;
							ratio_q <= '1;
						end else begin
							seg_q   <= seg_q + 1'b1;
							state_q <= T_READ;
						end
					end
				end
				T_DIV: begin
					dvd_q <= dvd_q << 1;
					if (drem_sh >= {1'b0, lmin_q}) begin
						drem_q <= drem_sh - {1'b0, lmin_q};
						quo_q  <= {quo_q[DVD_BITS-2:0], 1'b1};
					end else begin
						drem_q <= drem_sh;
						quo_q  <= {quo_q[DVD_BITS-2:0], 1'b0};
					end
					dcnt_q <= dcnt_q + 1'b1;
					if (dcnt_q == DCNT_BITS'(DVD_BITS - 1))
						state_q <= T_FIN;
				end
				T_FIN: begin
					if (!degen_q)
						ratio_q <= ratio_sat;
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_data_q  <= {5'd0, degen_q,
							(degen_q ? ratio_q : ratio_sat) > crit_q,
							DIAM_BITS'(diam_q),
							(degen_q ? ratio_q : ratio_sat)};
						state_q     <= T_IDLE;
					end
				end
				default: state_q <= T_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/hexq_seg_unit.sv -----
// Length of one segment: bit-serial squaring of the three differences, then
// a two-bits-per-cycle square root. Depends on hexq_pkg.
`default_nettype none
module hexq_seg_unit import hexq_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    start,
	input  wire vertex_t va,
	input  wire vertex_t vb,
	output logic         done,
	output len_t         length
);
	typedef enum logic [1:0] {S_IDLE, S_MUL, S_ROOT} st_t;

	localparam int MCAND_BITS = 2 * COORD_BITS;
	localparam int REM_BITS   = LEN_BITS + 3;
	localparam int CNT_BITS   = $clog2(LEN_BITS + 1);

	st_t                   state_q;
	coord_t                d_q [3];
	logic [1:0]            axis_q;
	logic [CNT_BITS-1:0]   cnt_q;
	logic [MCAND_BITS-1:0] mcand_q;
	coord_t                mplier_q;
	logic [SQ_BITS-1:0]    acc_q;
	logic [REM_BITS-1:0]   rem_q;
	len_t                  root_q;

	coord_t da [3];
	coord_t db [3];
	coord_t absd [3];
	logic [REM_BITS-1:0] rem_sh, trial;

	// offset-binary keeps order, so unsigned differences match signed ones
	always_comb begin
		da[0] = va.x ^ {1'b1, {(COORD_BITS-1){1'b0}}};
		da[1] = va.y ^ {1'b1, {(COORD_BITS-1){1'b0}}};
		da[2] = va.z ^ {1'b1, {(COORD_BITS-1){1'b0}}};
		db[0] = vb.x ^ {1'b1, {(COORD_BITS-1){1'b0}}};
		db[1] = vb.y ^ {1'b1, {(COORD_BITS-1){1'b0}}};
		db[2] = vb.z ^ {1'b1, {(COORD_BITS-1){1'b0}}};
		for (int k = 0; k < 3; k++)
			absd[k] = (da[k] > db[k]) ? da[k] - db[k] : db[k] - da[k];
		rem_sh = {rem_q[REM_BITS-3:0], acc_q[SQ_BITS-1 -: 2]};
		trial  = {1'b0, root_q, 2'b01};
	end

	assign length = root_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			done    <= 1'b0;
			axis_q  <= '0;
			cnt_q   <= '0;
		end else begin
			done <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						for (int k = 0; k < 3; k++) d_q[k] <= absd[k];
						mcand_q  <= MCAND_BITS'(absd[0]);
						mplier_q <= absd[0];
						acc_q    <= '0;
						axis_q   <= 2'd0;
						cnt_q    <= '0;
						state_q  <= S_MUL;
					end
				end
				S_MUL: begin
					if (mplier_q[0])
						acc_q <= acc_q + SQ_BITS'(mcand_q);
					mcand_q  <= mcand_q << 1;
					mplier_q <= mplier_q >> 1;
					cnt_q    <= cnt_q + 1'b1;
					if (cnt_q == CNT_BITS'(COORD_BITS - 1)) begin
						cnt_q <= '0;
						if (axis_q == 2'd2) begin
							rem_q   <= '0;
							root_q  <= '0;
							state_q <= S_ROOT;
						end else begin
							axis_q   <= axis_q + 1'b1;
							mcand_q  <= MCAND_BITS'(d_q[axis_q + 1'b1]);
							mplier_q <= d_q[axis_q + 1'b1];
						end
					end
				end
				S_ROOT: begin
					acc_q <= acc_q << 2;
					if (rem_sh >= trial) begin
						rem_q  <= rem_sh - trial;
						root_q <= {root_q[LEN_BITS-2:0], 1'b1};
					end else begin
						rem_q  <= rem_sh;
						root_q <= {root_q[LEN_BITS-2:0], 1'b0};
					end
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == CNT_BITS'(LEN_BITS - 1)) begin
						done    <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ----- rtl/hexq_checker.sv -----
// Port-level checks for the hex element quality top level, with its bind.
// Depends only on the top level's ports.
`default_nettype none
module hexq_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tvalid,
	input wire logic        s_tready,
	input wire logic [2:0]  s_tuser,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [63:0] m_tdata
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result dropped while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == 3'd7 |=> !s_tready)
		else $error("input taken during element run");
	a_degen: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[58] |-> m_tdata[31:0] == 32'hFFFF_FFFF)
		else $error("degenerate ratio not saturated");
	a_exceed: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[57] |-> m_tdata[31:0] != 32'd0)
		else $error("zero ratio flagged as exceeding");
endmodule

bind hex_element_quality_unit hexq_checker u_hexq_checker (.*);
`default_nettype wire

// ----- verif/tb_top.sv -----
// Testbench for hex_element_quality_unit: streams corner vertices, predicts edge aspect
// ratio, body diameter and flags per element, and checks every result request.
// Depends on hexq_pkg and the RTL of hex_element_quality_unit.
`timescale 1ns / 100ps
module tb_top;
	import hexq_pkg::*;

	localparam corner_t TRIGGER_CORNER = 3'd7;
	localparam logic [31:0] RATIO_SAT = 32'hFFFF_FFFF;
	localparam logic [24:0] DIAM_SAT = 25'h1FF_FFFF;
	localparam int IDLE_LIMIT = 40000;  // bound on idle time: one element run plus stalls
	localparam int SETTLE_CYCLES = 40;  // non-trigger corners only write the store
	localparam int RANDOM_ITEMS = 600;

	typedef struct {
		logic [31:0] ratio;
		logic [24:0] diam;
		logic        over_limit;
		logic        degen;
	} quality_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [2:0]  s_tuser = '0;
	logic [71:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [63:0] m_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;

	// predictor state: mirrored corner store and critical ratio
	coord_t      shadow_corner [8][3];
	logic [31:0] shadow_limit;
	quality_t    pending_quality [$];

	int  fail_count = 0;
	int  results_seen = 0;
	int  items_sent = 0;
	int  idle_cycles = 0;
	bit  no_gaps = 0;

	hex_element_quality_unit dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tuser(s_tuser), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Mostly short gaps, a few long ones; none while no_gaps is set.
	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (no_gaps || r < 65) return 0;
		if (r < 95) return $urandom_range(3, 1);
		return $urandom_range(60, 10);
	endfunction

	// Truncated square root; sum of three squares stays below 2^50.
	function automatic longint unsigned int_sqrt(input longint unsigned v);
		longint unsigned root, trial;
		root = 0;
		for (int b = 25; b >= 0; b--) begin
			trial = root | (64'd1 << b);
			if (trial * trial <= v) root = trial;
		end
		return root;
	endfunction

	function automatic longint unsigned corner_distance(input int a, input int b);
		longint signed d;
		longint unsigned acc;
		acc = 0;
		for (int k = 0; k < 3; k++) begin
			d = longint'($signed(shadow_corner[a][k])) - longint'($signed(shadow_corner[b][k]));
			if (d < 0) d = -d;
			acc += longint'(d) * longint'(d);
		end
		return int_sqrt(acc);
	endfunction

	function automatic quality_t predict_quality();
		int edge_a [12] = '{0, 1, 2, 0, 4, 5, 6, 4, 0, 1, 2, 3};
		int edge_b [12] = '{1, 2, 3, 3, 5, 6, 7, 7, 4, 5, 6, 7};
		int diag_a [4] = '{0, 1, 2, 3};
		int diag_b [4] = '{6, 7, 4, 5};
		longint unsigned len, longest, shortest, widest, quot;
		quality_t q;
		longest = 0;
		shortest = 0;
		widest = 0;
		for (int i = 0; i < 12; i++) begin
			len = corner_distance(edge_a[i], edge_b[i]);
			if (i == 0 || len > longest) longest = len;
			if (i == 0 || len < shortest) shortest = len;
		end
		for (int i = 0; i < 4; i++) begin
			len = corner_distance(diag_a[i], diag_b[i]);
			if (len > widest) widest = len;
		end
		q.degen = (shortest == 0);
		if (q.degen) begin
			q.ratio = RATIO_SAT;
		end else begin
			quot = (longest << RATIO_FRAC) / shortest;
			q.ratio = (quot > 64'hFFFF_FFFF) ? RATIO_SAT : quot[31:0];
		end
		q.diam = (widest > 64'h1FF_FFFF) ? DIAM_SAT : widest[24:0];
		q.over_limit = (q.ratio > shadow_limit);
		return q;
	endfunction

	// Send one corner request; called at a falling edge, returns at a falling edge.
	// tvalid is left high when no gap follows, so it is never lowered and raised
	// in the same step.
	task automatic send_corner(input corner_t c, input coord_t x, input coord_t y,
			input coord_t z);
		int gap;
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= {z, y, x};
		do @(posedge clk); while (!s_tready);
		shadow_corner[c][0] = x;
		shadow_corner[c][1] = y;
		shadow_corner[c][2] = z;
		if (c == TRIGGER_CORNER) pending_quality = {pending_quality, predict_quality()};
		items_sent++;
		@(negedge clk);
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
	endtask

	task automatic stop_sending();
		s_tvalid <= 1'b0;
		@(negedge clk);
	endtask

	// Wait for all results, then for any trailing corner writes to settle.
	task automatic drain();
		stop_sending();
		while (pending_quality.size() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_limit(input logic [31:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		shadow_limit = value;
		@(negedge clk);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Axis-aligned box with per-corner jitter; wraps at the coordinate width.
	task automatic send_box(input int bx, input int by, input int bz,
			input int sx, input int sy, input int sz, input int jitter);
		int cx, cy, cz;
		for (int i = 0; i < 8; i++) begin
			cx = bx + ((i == 1 || i == 2 || i == 5 || i == 6) ? sx : 0);
			cy = by + ((i == 2 || i == 3 || i == 6 || i == 7) ? sy : 0);
			cz = bz + ((i >= 4) ? sz : 0);
			if (jitter > 0) begin
				cx += $urandom_range(2 * jitter) - jitter;
				cy += $urandom_range(2 * jitter) - jitter;
				cz += $urandom_range(2 * jitter) - jitter;
			end
			send_corner(corner_t'(i), coord_t'(cx), coord_t'(cy), coord_t'(cz));
		end
	endtask

	task automatic test_unit_cube();
		no_gaps = 1;
		send_box(0, 0, 0, 65536, 65536, 65536, 0);   // ratio exactly 1.0
		no_gaps = 0;
		send_box(-65536, 131072, 7, 3 * 65536, 65536, 65536, 0);
		drain();
	endtask

	task automatic test_extremes();
		// opposite corners of the coordinate range: largest lengths and diameter
		send_box(-8388608, -8388608, -8388608, 16777215, 16777215, 16777215, 0);
		// every corner at the same point: all edges zero
		send_box(8388607, 8388607, 8388607, 0, 0, 0, 0);
		// one unit-long edge against full-range ones: ratio saturates
		send_box(-8388608, -8388608, -8388608, 16777215, 16777215, 16777215, 0);
		send_corner(3'd1, coord_t'(-8388607), coord_t'(-8388608), coord_t'(-8388608));
		send_corner(TRIGGER_CORNER, coord_t'(-8388608), coord_t'(8388607), coord_t'(8388607));
		// rewrite a lone corner and trigger again on the stored rest
		send_corner(3'd4, 24'h0, 24'h0, 24'h0);
		send_corner(TRIGGER_CORNER, 24'h555555, 24'hAAAAAA, 24'h800000);
		drain();
	endtask

	task automatic test_limit_settings();
		logic [31:0] limits [5] = '{32'h0, 32'h0001_0000, 32'h0002_FFFF, 32'h0000_0001,
			RATIO_SAT};
		foreach (limits[i]) begin
			write_limit(limits[i]);
			send_box(1000, -2000, 300, 65536, 65536, 65536, 0);       // ratio 1.0
			send_box(0, 0, 0, 3 * 65536, 65536, 65536, 0);            // ratio 3.0
			send_box(5, 5, 5, 0, 65536, 65536, 0);                    // degenerate
			drain();
		end
	endtask

	task automatic test_random_elements();
		int sent, scale, r;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			r = $urandom_range(99);
			if (r < 8) begin
				// noise: any corner, any bit pattern
				send_corner(corner_t'($urandom_range(7)), coord_t'($urandom),
					coord_t'($urandom), coord_t'($urandom));
				sent++;
			end else begin
				if (r < 12) no_gaps = 1;
				scale = $urandom_range(22);
				send_box($urandom_range(1 << 23) - (1 << 22), $urandom_range(1 << 23) - (1 << 22),
					$urandom_range(1 << 23) - (1 << 22),
					$urandom_range(1 << scale), $urandom_range(1 << scale),
					$urandom_range(1 << scale),
					(scale > 4 && $urandom_range(1)) ? $urandom_range(1 << (scale - 3)) : 0);
				no_gaps = 0;
				sent += 8;
			end
			if (sent >= RANDOM_ITEMS / 2 && sent < RANDOM_ITEMS / 2 + 9) begin
				// hold off the sender until every result is back, then retune
				drain();
				write_limit($urandom_range(4 * 65536, 65536));
			end
		end
		drain();
	endtask

	// Result side: random back-pressure, changed at the falling edge.
	initial begin
		int stall;
		forever begin
			@(negedge clk);
			stall = pick_gap();
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(negedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	// Compare each accepted result with the oldest prediction.
	always @(posedge clk) begin
		quality_t want;
		if (arst_n && m_tvalid && m_tready) begin
			results_seen++;
			if (pending_quality.size() == 0) begin
				fail_count++;
				$display("%0t: expected no result, got %h", $time, m_tdata);
			end else begin
				want = pending_quality.pop_front();
				if (m_tdata[31:0] !== want.ratio || m_tdata[56:32] !== want.diam ||
						m_tdata[57] !== want.over_limit || m_tdata[58] !== want.degen) begin
					fail_count++;
					$display("%0t: mismatch ratio %h/%h diam %h/%h over %b/%b degen %b/%b",
						$time, want.ratio, m_tdata[31:0], want.diam, m_tdata[56:32],
						want.over_limit, m_tdata[57], want.degen, m_tdata[58]);
				end
			end
		end
	end

	// Watchdog on cycles with no accepted request on any channel.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", pending_quality.size());
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		shadow_limit = RATIO_SAT;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_unit_cube();
		test_extremes();
		test_limit_settings();
		test_random_elements();
		$display("covered %0d corner requests and %0d element results across limit settings",
			items_sent, results_seen);
		if (fail_count == 0 && pending_quality.size() == 0) begin
			$display("status: pass");
		end else begin
			$display("%0d failures, %0d results missing", fail_count, pending_quality.size());
			$display("status: fail");
		end
		$finish;
	end
endmodule
